>>> rtl/tdlca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdlca_pkg
// Shared widths, defaults, operation codes and sequencer states of the
// tree distance / lowest common ancestor block.
// ----------------------------------------------------------------------------
package tdlca_pkg;

  localparam int NODE_W         = 10;
  localparam int DEPTH_W        = 10;
  localparam int NODES_DEFAULT  = 1024;
  localparam int LEVELS_DEFAULT = 10;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_STEP,
    ST_LD_WR,
    ST_Q_DEPTH,
    ST_Q_LIFT,
    ST_Q_CMP,
    ST_Q_LCA,
    ST_Q_DL
  } state_t;

endpackage

>>> rtl/tdlca_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdlca_in_if
// Request channel: a load (child, parent) or a query (two nodes).
// ----------------------------------------------------------------------------
interface tdlca_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [tdlca_pkg::NODE_W-1:0] first_node;
  logic [tdlca_pkg::NODE_W-1:0] second_node;

  modport source (output valid, output op, output first_node, output second_node,
                  input ready);
  modport sink   (input valid, input op, input first_node, input second_node,
                  output ready);
endinterface

>>> rtl/tdlca_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdlca_out_if
// Response channel: path distance and lowest common ancestor of a query.
// ----------------------------------------------------------------------------
interface tdlca_out_if;
  logic                          valid;
  logic                          ready;
  logic [tdlca_pkg::DEPTH_W-1:0] distance;
  logic [tdlca_pkg::NODE_W-1:0]  common_ancestor;

  modport source (output valid, output distance, output common_ancestor, input ready);
  modport sink   (input valid, input distance, input common_ancestor, output ready);
endinterface

>>> rtl/tree_distance_lca_binary_lifting.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_distance_lca_binary_lifting
// Rooted tree held as a binary-lifting table; answers LCA and path distance.
// ----------------------------------------------------------------------------
// Usage:
//   req carries op, first_node and second_node. A load (op 0) hangs
//   first_node under second_node and fills its ancestor levels; it gives
//   no response. A query (op 1) returns distance and common_ancestor on rsp.
//   One row per node holds the depth and all LEVELS ancestors, in a memory
//   with two read ports and one write port, with registered read data.
//   Steps: one item at a time. A load reads one row per ancestor level,
//   then writes the row. A query runs accept and depth read, depth compare,
//   one lift step per level, one compare step per level, ancestor fetch
//   and depth fetch; when the lifted nodes already meet, it skips the
//   compare steps and the ancestor fetch.
//   req.ready is high between items; the next item is taken while a
//   response still waits in the output register.
//   Reset: a clearing pass writes zero rows over all NODES entries, with
//   req.ready low throughout.
//   Stall: a query that finishes while the previous response is not yet
//   taken holds in its last step until the output register frees.
// ----------------------------------------------------------------------------
module tree_distance_lca_binary_lifting #(
  parameter int NODES  = tdlca_pkg::NODES_DEFAULT,
  parameter int LEVELS = tdlca_pkg::LEVELS_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  tdlca_in_if.sink    req,
  tdlca_out_if.source rsp
);

  localparam int NW = tdlca_pkg::NODE_W;
  localparam int DW = tdlca_pkg::DEPTH_W;
  localparam int AW = $clog2(NODES);
  localparam int LW = $clog2(LEVELS);
  localparam int RW = DW + LEVELS * NW;

  localparam logic [AW-1:0] LAST_ADDR  = AW'(NODES - 1);
  localparam logic [LW-1:0] LAST_LEVEL = LW'(LEVELS - 1);

  tdlca_pkg::state_t state, state_next;

  logic [RW-1:0] mem [NODES];
  logic [RW-1:0] rd0, rd1;
  logic [AW-1:0] rd_addr0, rd_addr1, wr_addr;
  logic [RW-1:0] wr_data;
  logic          wr_en;

  logic [NW-1:0] anc_u [LEVELS];
  logic [NW-1:0] anc_v [LEVELS];
  logic [DW-1:0] dep_u, dep_v;

  logic [AW-1:0] clr, clr_next;
  logic [LW-1:0] lvl, lvl_next;
  logic [NW-1:0] u, u_next, v, v_next;
  logic [NW-1:0] child, child_next;
  logic [NW-1:0] lca, lca_next;
  logic [DW-1:0] da, da_next, db, db_next;
  logic [DW-1:0] gap, gap_next;
  logic [NW-1:0] lev [LEVELS];
  logic [DW-1:0] ldep, ldep_next;
  logic [NW-1:0] step_val;
  logic [RW-1:0] ld_row;

  logic          out_valid, out_load;
  logic [DW-1:0] out_dist, dist_calc;
  logic [NW-1:0] out_lca;

  logic          first_ok, second_ok;
  logic [NW-1:0] qa, qb;

  assign first_ok  = 32'(req.first_node) < NODES;
  assign second_ok = 32'(req.second_node) < NODES;
  assign qa        = first_ok  ? req.first_node  : '0;
  assign qb        = second_ok ? req.second_node : '0;

  // Row memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd0 <= mem[rd_addr0];
    rd1 <= mem[rd_addr1];
  end

  always_comb begin
    for (int j = 0; j < LEVELS; j++) begin
      anc_u[j] = rd0[j*NW +: NW];
      anc_v[j] = rd1[j*NW +: NW];
      ld_row[j*NW +: NW] = lev[j];
    end
    ld_row[LEVELS*NW +: DW] = ldep;
    dep_u = rd0[LEVELS*NW +: DW];
    dep_v = rd1[LEVELS*NW +: DW];
  end

  assign step_val  = (u == child) ? child : anc_u[lvl - LW'(1)];
  assign dist_calc = da + db - (dep_u << 1);
  assign out_load  = (state == tdlca_pkg::ST_Q_DL) && (!out_valid || rsp.ready);

  assign req.ready           = (state == tdlca_pkg::ST_IDLE);
  assign rsp.valid           = out_valid;
  assign rsp.distance        = out_dist;
  assign rsp.common_ancestor = out_lca;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tdlca_pkg::ST_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl   <= lvl_next;
    u     <= u_next;
    v     <= v_next;
    child <= child_next;
    lca   <= lca_next;
    da    <= da_next;
    db    <= db_next;
    gap   <= gap_next;
    ldep  <= ldep_next;
    if (state == tdlca_pkg::ST_IDLE) begin
      lev[0] <= req.second_node;
    end else if (state == tdlca_pkg::ST_LD_STEP) begin
      lev[lvl] <= step_val;
    end
    if (out_load) begin
      out_dist <= dist_calc;
      out_lca  <= lca;
    end
  end

  always_comb begin
    state_next = state;
    clr_next   = clr;
    lvl_next   = lvl;
    u_next     = u;
    v_next     = v;
    child_next = child;
    lca_next   = lca;
    da_next    = da;
    db_next    = db;
    gap_next   = gap;
    ldep_next  = ldep;
    rd_addr0   = AW'(u);
    rd_addr1   = AW'(v);
    wr_en      = 1'b0;
    wr_addr    = AW'(child);
    wr_data    = ld_row;
    case (state)
      tdlca_pkg::ST_CLEAR: begin
        wr_en    = 1'b1;
        wr_addr  = clr;
        wr_data  = '0;
        clr_next = clr + AW'(1);
        if (clr == LAST_ADDR) begin
          state_next = tdlca_pkg::ST_IDLE;
        end
      end
      tdlca_pkg::ST_IDLE: begin
        if (req.op == tdlca_pkg::OP_LOAD) begin
          rd_addr0 = AW'(req.second_node);
        end else begin
          rd_addr0 = AW'(qa);
          rd_addr1 = AW'(qb);
        end
        if (req.valid) begin
          lvl_next = LW'(1);
          if (req.op == tdlca_pkg::OP_QUERY) begin
            u_next     = qa;
            v_next     = qb;
            state_next = tdlca_pkg::ST_Q_DEPTH;
          end else if (req.first_node != '0 && first_ok && second_ok) begin
            child_next = req.first_node;
            u_next     = req.second_node;
            state_next = tdlca_pkg::ST_LD_STEP;
          end
        end
      end
      tdlca_pkg::ST_LD_STEP: begin
        if (lvl == LW'(1)) begin
          ldep_next = (dep_u == tdlca_pkg::DEPTH_MAX) ? tdlca_pkg::DEPTH_MAX
                                                     : dep_u + DW'(1);
        end
        u_next   = step_val;
        rd_addr0 = AW'(step_val);
        lvl_next = lvl + LW'(1);
        if (lvl == LAST_LEVEL) begin
          state_next = tdlca_pkg::ST_LD_WR;
        end
      end
      tdlca_pkg::ST_LD_WR: begin
        wr_en      = 1'b1;
        state_next = tdlca_pkg::ST_IDLE;
      end
      tdlca_pkg::ST_Q_DEPTH: begin
        da_next  = dep_u;
        db_next  = dep_v;
        lvl_next = '0;
        if (dep_u < dep_v) begin
          u_next   = v;
          v_next   = u;
          gap_next = dep_v - dep_u;
        end else begin
          gap_next = dep_u - dep_v;
        end
        rd_addr0   = AW'(u_next);
        rd_addr1   = AW'(v_next);
        state_next = tdlca_pkg::ST_Q_LIFT;
      end
      tdlca_pkg::ST_Q_LIFT: begin
        if (gap[0]) begin
          u_next = anc_u[lvl];
        end
        gap_next = gap >> 1;
        rd_addr0 = AW'(u_next);
        if (lvl == LAST_LEVEL) begin
          state_next = tdlca_pkg::ST_Q_CMP;
        end else begin
          lvl_next = lvl + LW'(1);
        end
      end
      tdlca_pkg::ST_Q_CMP: begin
        if (u == v) begin
          lca_next   = u;
          rd_addr0   = AW'(u);
          state_next = tdlca_pkg::ST_Q_DL;
        end else begin
          if (anc_u[lvl] != anc_v[lvl]) begin
            u_next = anc_u[lvl];
            v_next = anc_v[lvl];
          end
          rd_addr0 = AW'(u_next);
          rd_addr1 = AW'(v_next);
          if (lvl == '0) begin
            state_next = tdlca_pkg::ST_Q_LCA;
          end else begin
            lvl_next = lvl - LW'(1);
          end
        end
      end
      tdlca_pkg::ST_Q_LCA: begin
        lca_next   = anc_u[0];
        rd_addr0   = AW'(anc_u[0]);
        state_next = tdlca_pkg::ST_Q_DL;
      end
      tdlca_pkg::ST_Q_DL: begin
        rd_addr0 = AW'(lca);
        if (out_load) begin
          state_next = tdlca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tdlca_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_write_window: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == tdlca_pkg::ST_CLEAR || state == tdlca_pkg::ST_LD_WR))
    else $error("row write outside clear pass or load commit");

  a_rsp_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == tdlca_pkg::ST_Q_DL)
    else $error("response raised without a finished query");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    (state == tdlca_pkg::ST_Q_LIFT || state == tdlca_pkg::ST_Q_CMP
     || state == tdlca_pkg::ST_LD_STEP) |-> 32'(lvl) < LEVELS)
    else $error("level counter out of range");

  a_load_commit: assert property (@(posedge clk) disable iff (rst)
    (state == tdlca_pkg::ST_LD_WR) |-> child != '0)
    else $error("commit of the sentinel row");
`endif

endmodule

>>> tb/tb_tree_distance_lca_binary_lifting.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tree_distance_lca_binary_lifting
// Self-checking bench for the binary-lifting LCA and path distance block.
// Loads and queries go in on the request channel. A local copy of the depth
// and ancestor tables works out the expected answer of each accepted query.
// Each response is compared field by field with the oldest waiting answer.
// Directed trees cover the empty tree, ignored loads, unloaded parents,
// cycles, reloads and depth saturation. A long response stall and a long
// random part follow, with idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_tree_distance_lca_binary_lifting;

  localparam int TREE_NODES  = tdlca_pkg::NODES_DEFAULT;
  localparam int TREE_LEVELS = tdlca_pkg::LEVELS_DEFAULT;
  localparam int SETTLE_CYCLES = 2 * TREE_LEVELS + 8;

  typedef logic [tdlca_pkg::NODE_W-1:0]  node_t;
  typedef logic [tdlca_pkg::DEPTH_W-1:0] depth_t;

  typedef struct packed {
    depth_t distance;
    node_t  common_ancestor;
  } answer_t;

  logic clk;
  logic rst;

  tdlca_in_if  req_bus ();
  tdlca_out_if rsp_bus ();

  tree_distance_lca_binary_lifting DUT (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  node_t   tree_anc [TREE_NODES][TREE_LEVELS];
  depth_t  tree_depth [TREE_NODES];
  answer_t pending_answers [$];
  node_t   placed_nodes [$];

  int fail_count;
  int loads_sent;
  int queries_sent;
  int answers_checked;
  int hold_request;
  int hold_left;
  bit no_idle;

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("Timeout at %0t with %0d answers outstanding", $time, pending_answers.size());
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bit predict_item(input logic op, input node_t a, input node_t b,
                                      output answer_t ans);
    node_t  u;
    node_t  v;
    node_t  t;
    node_t  mid;
    node_t  au;
    node_t  av;
    node_t  lca;
    depth_t gap;
    logic [tdlca_pkg::DEPTH_W:0] d;
    ans = '0;
    if (op == tdlca_pkg::OP_LOAD) begin
      if (a == 0 || int'(a) >= TREE_NODES || int'(b) >= TREE_NODES) return 1'b0;
      d = {1'b0, tree_depth[b]} + 1'b1;
      tree_depth[a] = (d > tdlca_pkg::DEPTH_MAX) ? tdlca_pkg::DEPTH_MAX
                                                 : d[tdlca_pkg::DEPTH_W-1:0];
      tree_anc[a][0] = b;
      for (int j = 1; j < TREE_LEVELS; j++) begin
        mid = tree_anc[a][j-1];
        tree_anc[a][j] = tree_anc[mid][j-1];
      end
      return 1'b0;
    end
    u = (int'(a) < TREE_NODES) ? a : '0;
    v = (int'(b) < TREE_NODES) ? b : '0;
    a = u;
    b = v;
    if (tree_depth[u] < tree_depth[v]) begin
      t = u;
      u = v;
      v = t;
    end
    gap = tree_depth[u] - tree_depth[v];
    for (int j = 0; j < TREE_LEVELS; j++) begin
      if (gap[j]) u = tree_anc[u][j];
    end
    if (u == v) begin
      lca = u;
    end else begin
      for (int j = TREE_LEVELS - 1; j >= 0; j--) begin
        au = tree_anc[u][j];
        av = tree_anc[v][j];
        if (au != av) begin
          u = au;
          v = av;
        end
      end
      lca = tree_anc[u][0];
    end
    ans.distance = tree_depth[a] + tree_depth[b] - (tree_depth[lca] << 1);
    ans.common_ancestor = lca;
    return 1'b1;
  endfunction

  task automatic send_item(input logic op, input node_t a, input node_t b);
    answer_t ans;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 6) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.op          <= op;
    req_bus.first_node  <= a;
    req_bus.second_node <= b;
    do @(posedge clk); while (!req_bus.ready);
    if (op == tdlca_pkg::OP_QUERY) queries_sent++;
    else loads_sent++;
    if (predict_item(op, a, b, ans)) pending_answers.push_back(ans);
  endtask

  task automatic idle_bus();
    @(negedge clk);
    req_bus.valid <= 1'b0;
  endtask

  task automatic wait_all_answers();
    idle_bus();
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(99) < 6) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_answers
    answer_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual distance %0d ancestor %0d",
                 $time, rsp_bus.distance, rsp_bus.common_ancestor);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        answers_checked++;
        if (rsp_bus.distance !== want.distance) begin
          $display("%0t: distance mismatch, expected %0d, actual %0d",
                   $time, want.distance, rsp_bus.distance);
          fail_count++;
        end
        if (rsp_bus.common_ancestor !== want.common_ancestor) begin
          $display("%0t: common_ancestor mismatch, expected %0d, actual %0d",
                   $time, want.common_ancestor, rsp_bus.common_ancestor);
          fail_count++;
        end
      end
    end
  end

  task automatic test_empty_tree();
    send_item(tdlca_pkg::OP_QUERY, 10'd0, 10'd0);
    send_item(tdlca_pkg::OP_QUERY, 10'd1, 10'd1023);
    send_item(tdlca_pkg::OP_QUERY, 10'd1023, 10'd0);
  endtask

  task automatic test_odd_loads();
    // sentinel load is dropped; an unloaded parent counts as depth zero
    send_item(tdlca_pkg::OP_LOAD, 10'd0, 10'd5);
    send_item(tdlca_pkg::OP_LOAD, 10'd700, 10'd900);
    send_item(tdlca_pkg::OP_QUERY, 10'd700, 10'd1);
    send_item(tdlca_pkg::OP_QUERY, 10'd700, 10'd900);
  endtask

  task automatic test_small_tree();
    send_item(tdlca_pkg::OP_LOAD, 10'd2, 10'd1);
    send_item(tdlca_pkg::OP_LOAD, 10'd3, 10'd1);
    send_item(tdlca_pkg::OP_LOAD, 10'd4, 10'd2);
    send_item(tdlca_pkg::OP_LOAD, 10'd5, 10'd2);
    send_item(tdlca_pkg::OP_LOAD, 10'd6, 10'd3);
    send_item(tdlca_pkg::OP_LOAD, 10'd7, 10'd4);
    send_item(tdlca_pkg::OP_QUERY, 10'd7, 10'd5);
    send_item(tdlca_pkg::OP_QUERY, 10'd7, 10'd6);
    send_item(tdlca_pkg::OP_QUERY, 10'd4, 10'd7);
    send_item(tdlca_pkg::OP_QUERY, 10'd6, 10'd6);
    send_item(tdlca_pkg::OP_QUERY, 10'd1, 10'd7);
  endtask

  task automatic test_field_extremes();
    send_item(tdlca_pkg::OP_LOAD, 10'd1023, 10'd7);
    send_item(tdlca_pkg::OP_QUERY, 10'd1023, 10'd1023);
    send_item(tdlca_pkg::OP_QUERY, 10'd1023, 10'd0);
    send_item(tdlca_pkg::OP_QUERY, 10'd5, 10'd1023);
  endtask

  task automatic test_reload_and_cycle();
    send_item(tdlca_pkg::OP_LOAD, 10'd3, 10'd6);
    send_item(tdlca_pkg::OP_QUERY, 10'd6, 10'd2);
    send_item(tdlca_pkg::OP_LOAD, 10'd4, 10'd5);
    send_item(tdlca_pkg::OP_QUERY, 10'd7, 10'd5);
    send_item(tdlca_pkg::OP_QUERY, 10'd3, 10'd6);
  endtask

  task automatic test_depth_saturation();
    // ping-pong two nodes so each reload adds one level, past the depth limit
    no_idle = 1'b1;
    for (int i = 0; i < 1030; i++) begin
      if (i[0]) send_item(tdlca_pkg::OP_LOAD, 10'd1001, 10'd1000);
      else send_item(tdlca_pkg::OP_LOAD, 10'd1000, 10'd1001);
    end
    send_item(tdlca_pkg::OP_QUERY, 10'd1000, 10'd1);
    send_item(tdlca_pkg::OP_QUERY, 10'd1001, 10'd1000);
    send_item(tdlca_pkg::OP_QUERY, 10'd2, 10'd1001);
    send_item(tdlca_pkg::OP_QUERY, 10'd1001, 10'd1001);
    no_idle = 1'b0;
    wait_all_answers();
  endtask

  task automatic test_response_stall();
    hold_request = 300;
    @(negedge clk);
    @(negedge clk);
    for (int i = 0; i < 10; i++) begin
      send_item(tdlca_pkg::OP_QUERY, node_t'($urandom_range(1, 7)),
                node_t'($urandom_range(1, 7)));
    end
    wait_all_answers();
  endtask

  task automatic test_random_tree();
    int    pick;
    node_t child;
    node_t parent;
    node_t qa;
    node_t qb;
    placed_nodes = {10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6, 10'd7};
    for (int i = 0; i < 500; i++) begin
      if (i == 250) wait_all_answers();
      pick = $urandom_range(99);
      if (pick < 35) begin
        child  = node_t'($urandom_range(2, TREE_NODES - 1));
        parent = placed_nodes[$urandom_range(placed_nodes.size() - 1)];
        send_item(tdlca_pkg::OP_LOAD, child, parent);
        placed_nodes.push_back(child);
      end else if (pick < 80) begin
        qa = placed_nodes[$urandom_range(placed_nodes.size() - 1)];
        qb = placed_nodes[$urandom_range(placed_nodes.size() - 1)];
        send_item(tdlca_pkg::OP_QUERY, qa, qb);
      end else if (pick < 90) begin
        send_item(tdlca_pkg::OP_QUERY, node_t'($urandom), node_t'($urandom));
      end else begin
        send_item(tdlca_pkg::OP_LOAD, node_t'($urandom), node_t'($urandom));
      end
    end
    wait_all_answers();
  endtask

  initial begin
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.op = tdlca_pkg::OP_LOAD;
    req_bus.first_node = '0;
    req_bus.second_node = '0;
    rsp_bus.ready = 1'b0;
    fail_count = 0;
    loads_sent = 0;
    queries_sent = 0;
    answers_checked = 0;
    hold_request = 0;
    hold_left = 0;
    no_idle = 1'b0;
    for (int n = 0; n < TREE_NODES; n++) begin
      tree_depth[n] = '0;
      for (int j = 0; j < TREE_LEVELS; j++) tree_anc[n][j] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_tree();
    test_odd_loads();
    test_small_tree();
    test_field_extremes();
    test_reload_and_cycle();
    test_depth_saturation();
    test_response_stall();
    test_random_tree();

    wait_all_answers();
    $display("Run covered %0d loads and %0d queries, %0d answers compared.",
             loads_sent, queries_sent, answers_checked);
    $display("Included empty tree, cycles, reloads, saturated depth and a long response stall.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
